### rtl/core/rrq_pkg.sv
// round robin run queue: shared package
// command codes, task state codes and the queue operation struct
// no dependencies
`default_nettype none

package rrq_pkg;

    localparam int ID_W  = 4;
    localparam int CMD_W = 2;
    localparam int TST_W = 2;

    typedef logic [CMD_W-1:0] rrq_cmd_t;
    typedef logic [TST_W-1:0] rrq_tstate_t;
    typedef logic [ID_W-1:0]  rrq_id_t;

    localparam rrq_cmd_t CMD_CREATE  = 2'd0;
    localparam rrq_cmd_t CMD_START   = 2'd1;
    localparam rrq_cmd_t CMD_RESCHED = 2'd2;
    localparam rrq_cmd_t CMD_EXIT    = 2'd3;

    localparam rrq_tstate_t ST_INITIAL = 2'd0;
    localparam rrq_tstate_t ST_READY   = 2'd1;
    localparam rrq_tstate_t ST_RUNNING = 2'd2;
    localparam rrq_tstate_t ST_DEAD    = 2'd3;

    typedef struct packed {
        logic    rd;
        logic    push_head;
        logic    push_tail;
        logic    pop;
        rrq_id_t id;
    } rrq_qop_t;

endpackage

`default_nettype wire

### rtl/core/rrq_ram.sv
// round robin run queue: generic single-port-write ram
// one write port, one read port with registered read data
// no dependencies
`default_nettype none

module rrq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/rrq_state_mem.sv
// round robin run queue: per-task state store
// state ram plus per-entry valid bits that supply the reset state
// depends on rrq_pkg, rrq_ram
`default_nettype none

module rrq_state_mem #(
    parameter int TASK_COUNT = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(TASK_COUNT)-1:0] rd_addr,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(TASK_COUNT)-1:0] wr_addr,
    input  wire rrq_pkg::rrq_tstate_t          wr_data,
    output rrq_pkg::rrq_tstate_t               rd_data
);

    localparam int IDX_W = $clog2(TASK_COUNT);

    logic [TASK_COUNT-1:0] valid_reg;
    logic [TASK_COUNT-1:0] valid_next;
    logic                  rd_valid_reg;
    logic                  rd_zero_reg;
    rrq_pkg::rrq_tstate_t  ram_q;

    rrq_ram #(
        .WIDTH (rrq_pkg::TST_W),
        .DEPTH (TASK_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_zero_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
                rd_zero_reg  <= (rd_addr == IDX_W'(0));
            end
        end
    end

    // unwritten entries read as the reset state
    assign rd_data = rd_valid_reg ? ram_q
                   : (rd_zero_reg ? rrq_pkg::ST_INITIAL : rrq_pkg::ST_DEAD);

endmodule

`default_nettype wire

### rtl/core/rrq_queue.sv
// round robin run queue: ready deque
// ring of task numbers in a ram with head pointer and fill count
// depends on rrq_pkg, rrq_ram
`default_nettype none

module rrq_queue #(
    parameter int TASK_COUNT = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire rrq_pkg::rrq_qop_t op,
    output logic                  empty,
    output rrq_pkg::rrq_id_t      head_data
);

    localparam int IDX_W = $clog2(TASK_COUNT);
    localparam int CNT_W = $clog2(TASK_COUNT + 1);

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail;
    logic             full;
    logic             push_h;
    logic             push_t;
    logic             pop;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    assign full     = (count_reg == CNT_W'(TASK_COUNT));
    assign empty    = (count_reg == CNT_W'(0));
    assign head_inc = (head_reg == IDX_W'(TASK_COUNT - 1)) ? IDX_W'(0) : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == IDX_W'(0)) ? IDX_W'(TASK_COUNT - 1) : head_reg - IDX_W'(1);
    assign tail_sum = (IDX_W + 1)'(head_reg) + (IDX_W + 1)'(count_reg);
    assign tail     = (tail_sum >= (IDX_W + 1)'(TASK_COUNT))
                    ? IDX_W'(tail_sum - (IDX_W + 1)'(TASK_COUNT)) : IDX_W'(tail_sum);

    assign push_h  = op.push_head && !full;
    assign push_t  = op.push_tail && !full;
    assign pop     = op.pop && (!empty || push_t);
    assign wr_en   = push_h || push_t;
    assign wr_addr = push_h ? head_dec : tail;

    always_comb
    begin
        head_next = head_reg;
        if (push_h)
        begin
            head_next = head_dec;
        end
        else if (pop)
        begin
            head_next = head_inc;
        end
        count_next = count_reg;
        case ({wr_en, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    rrq_ram #(
        .WIDTH (rrq_pkg::ID_W),
        .DEPTH (TASK_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (op.id),
        .rd_en   (op.rd),
        .rd_addr (head_reg),
        .rd_data (head_data)
    );

endmodule

`default_nettype wire

### rtl/core/round_robin_run_queue_unit.sv
// round robin run queue: top level with command sequencer
// usage: one command per input transfer (create, start, reschedule, exit)
// and exactly one result transfer per command with status, switch flag,
// previous and new current task. Task 0 is the idle task.
// timing: the input transfer launches reads of the task state ram and of
// the deque head slot; the next cycle decides and writes back, and the
// result is registered at the end of that cycle. A reschedule or exit
// that switches tasks passes through an extra finish state, a second
// access of the single state ram write port that marks the new task
// running. in_ready is low while a command is in flight.
// reset: task 0 initial, all other tasks dead, deque empty, current task 0;
// the state ram needs no clearing pass, per-entry valid bits stand in.
// stall: the result register holds until out_ready; once idle, a new command
// is taken in the cycle the pending result is transferred, but not before.
// depends on rrq_pkg, rrq_state_mem, rrq_queue
`default_nettype none

module round_robin_run_queue_unit #(
    parameter int TASK_COUNT = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire rrq_pkg::rrq_cmd_t command,
    input  wire rrq_pkg::rrq_id_t task_id,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  status,
    output logic                  switched,
    output rrq_pkg::rrq_id_t      previous_task,
    output rrq_pkg::rrq_id_t      running_task
);

    localparam int IDX_W = $clog2(TASK_COUNT);
    localparam int EXT_W = rrq_pkg::ID_W + IDX_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]           fsm_reg;
    logic [1:0]           fsm_next;
    rrq_pkg::rrq_cmd_t    cmd_reg;
    rrq_pkg::rrq_id_t     id_reg;
    rrq_pkg::rrq_id_t     current_reg;
    rrq_pkg::rrq_id_t     current_next;
    rrq_pkg::rrq_id_t     nxt_id_reg;
    rrq_pkg::rrq_id_t     nxt_id_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 status_reg;
    logic                 switched_reg;
    rrq_pkg::rrq_id_t     prev_reg;
    rrq_pkg::rrq_id_t     run_reg;

    logic                 accept;
    logic                 res_load;
    logic                 res_status;
    logic                 res_sw;
    rrq_pkg::rrq_id_t     res_run;

    logic [EXT_W-1:0]     in_id_ext;
    logic [EXT_W-1:0]     id_ext;
    logic [EXT_W-1:0]     cur_ext;
    logic [EXT_W-1:0]     nxt_ext;
    logic                 id_ok;

    logic                 st_rd_en;
    logic [IDX_W-1:0]     st_rd_addr;
    logic                 st_wr_en;
    logic [IDX_W-1:0]     st_wr_addr;
    rrq_pkg::rrq_tstate_t st_wr_data;
    rrq_pkg::rrq_tstate_t st_rdata;

    rrq_pkg::rrq_qop_t    qop;
    logic                 q_empty;
    rrq_pkg::rrq_id_t     q_head;
    logic                 requeued;
    rrq_pkg::rrq_id_t     pick;

    assign in_ready = (fsm_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign in_id_ext = EXT_W'(task_id);
    assign id_ext    = EXT_W'(id_reg);
    assign cur_ext   = EXT_W'(current_reg);
    assign nxt_ext   = EXT_W'(nxt_id_reg);
    assign id_ok     = (id_ext < EXT_W'(TASK_COUNT));

    rrq_state_mem #(
        .TASK_COUNT (TASK_COUNT)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_data (st_rdata)
    );

    rrq_queue #(
        .TASK_COUNT (TASK_COUNT)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (qop),
        .empty     (q_empty),
        .head_data (q_head)
    );

    assign requeued = (cmd_reg == rrq_pkg::CMD_RESCHED) && (st_rdata == rrq_pkg::ST_RUNNING);

    always_comb
    begin
        if (!q_empty)
        begin
            pick = q_head;
        end
        else if (requeued)
        begin
            pick = current_reg;
        end
        else
        begin
            pick = '0;
        end
    end

    always_comb
    begin
        fsm_next     = fsm_reg;
        current_next = current_reg;
        nxt_id_next  = nxt_id_reg;
        st_rd_en     = 1'b0;
        st_rd_addr   = ((command == rrq_pkg::CMD_CREATE) || (command == rrq_pkg::CMD_START))
                     ? in_id_ext[IDX_W-1:0] : cur_ext[IDX_W-1:0];
        st_wr_en     = 1'b0;
        st_wr_addr   = id_ext[IDX_W-1:0];
        st_wr_data   = rrq_pkg::ST_DEAD;
        qop          = '0;
        qop.rd       = accept;
        qop.id       = id_reg;
        res_load     = 1'b0;
        res_status   = 1'b0;
        res_sw       = 1'b0;
        res_run      = current_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    st_rd_en = 1'b1;
                    fsm_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_load = 1'b1;
                fsm_next = S_IDLE;
                unique case (cmd_reg) inside
                    rrq_pkg::CMD_CREATE:
                    begin
                        if (!id_ok || (st_rdata == rrq_pkg::ST_READY)
                            || (st_rdata == rrq_pkg::ST_RUNNING))
                        begin
                            res_status = 1'b1;
                        end
                        else
                        begin
                            st_wr_en   = 1'b1;
                            st_wr_data = rrq_pkg::ST_INITIAL;
                        end
                    end
                    rrq_pkg::CMD_START:
                    begin
                        if (!id_ok || (st_rdata != rrq_pkg::ST_INITIAL))
                        begin
                            res_status = 1'b1;
                        end
                        else
                        begin
                            st_wr_en      = 1'b1;
                            st_wr_data    = rrq_pkg::ST_READY;
                            qop.push_head = 1'b1;
                        end
                    end
                    rrq_pkg::CMD_RESCHED, rrq_pkg::CMD_EXIT:
                    begin
                        qop.id        = current_reg;
                        qop.push_tail = requeued;
                        qop.pop       = requeued || !q_empty;
                        st_wr_addr    = cur_ext[IDX_W-1:0];
                        if (cmd_reg == rrq_pkg::CMD_EXIT)
                        begin
                            st_wr_en   = 1'b1;
                            st_wr_data = rrq_pkg::ST_DEAD;
                        end
                        else if (requeued && (pick != current_reg))
                        begin
                            st_wr_en   = 1'b1;
                            st_wr_data = rrq_pkg::ST_READY;
                        end
                        if (pick != current_reg)
                        begin
                            current_next = pick;
                            nxt_id_next  = pick;
                            res_sw       = 1'b1;
                            res_run      = pick;
                            fsm_next     = S_FINISH;
                        end
                    end
                    default:
                    begin
                        res_status = 1'b0;
                    end
                endcase
            end
            S_FINISH:
            begin
                st_wr_en   = 1'b1;
                st_wr_addr = nxt_ext[IDX_W-1:0];
                st_wr_data = rrq_pkg::ST_RUNNING;
                fsm_next   = S_IDLE;
            end
            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            current_reg   <= current_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_id_reg <= nxt_id_next;
        if (accept)
        begin
            cmd_reg <= command;
            id_reg  <= task_id;
        end
        if (res_load)
        begin
            status_reg   <= res_status;
            switched_reg <= res_sw;
            prev_reg     <= current_reg;
            run_reg      <= res_run;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign switched      = switched_reg;
    assign previous_task = prev_reg;
    assign running_task  = run_reg;

endmodule

`default_nettype wire

### bench/tb_round_robin_run_queue_unit.sv
// testbench for round_robin_run_queue_unit: directed command table, then random
// command streams checked against a scheduler predictor with random stalls
// depends on rrq_pkg and round_robin_run_queue_unit
`default_nettype none

module tb_round_robin_run_queue_unit;

    localparam int TASKS        = 16;
    localparam int RANDOM_ITEMS = 550;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic             status;
        logic             switched;
        rrq_pkg::rrq_id_t prev;
        rrq_pkg::rrq_id_t run;
    } sched_outcome_t;

    typedef struct packed {
        rrq_pkg::rrq_cmd_t cmd;
        rrq_pkg::rrq_id_t  id;
        logic              typed;
        sched_outcome_t    res;
    } plan_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    rrq_pkg::rrq_cmd_t command = rrq_pkg::CMD_CREATE;
    rrq_pkg::rrq_id_t  task_id = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              status;
    logic              switched;
    rrq_pkg::rrq_id_t  previous_task;
    rrq_pkg::rrq_id_t  running_task;

    logic gaps_on = 1'b1;

    // scheduler image
    rrq_pkg::rrq_tstate_t task_st [TASKS];
    rrq_pkg::rrq_id_t     ring [TASKS];
    int unsigned          ring_head;
    int unsigned          ring_count;
    rrq_pkg::rrq_id_t     cur_task;

    sched_outcome_t outcome_q [$];
    plan_row_t      plan_q [$];
    sched_outcome_t want;
    sched_outcome_t got;

    int fail_count    = 0;
    int sent_count    = 0;
    int results_seen  = 0;
    int switches_seen = 0;
    int rejects_seen  = 0;

    round_robin_run_queue_unit #(
        .TASK_COUNT(TASKS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .task_id       (task_id),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .switched      (switched),
        .previous_task (previous_task),
        .running_task  (running_task)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void ring_push_head(rrq_pkg::rrq_id_t id);
        if (ring_count >= TASKS)
            return;
        ring_head = (ring_head + TASKS - 1) % TASKS;
        ring[ring_head] = id;
        ring_count++;
    endfunction

    function automatic void ring_push_tail(rrq_pkg::rrq_id_t id);
        if (ring_count >= TASKS)
            return;
        ring[(ring_head + ring_count) % TASKS] = id;
        ring_count++;
    endfunction

    function automatic logic ring_pop(output rrq_pkg::rrq_id_t id);
        id = '0;
        if (ring_count == 0)
            return 1'b0;
        id = ring[ring_head];
        ring_head = (ring_head + 1) % TASKS;
        ring_count--;
        return 1'b1;
    endfunction

    function automatic logic pick_next_task();
        rrq_pkg::rrq_id_t old_id;
        rrq_pkg::rrq_id_t nxt;
        logic             requeued;
        old_id = cur_task;
        requeued = 1'b0;
        if (task_st[old_id] == rrq_pkg::ST_RUNNING)
        begin
            task_st[old_id] = rrq_pkg::ST_READY;
            ring_push_tail(old_id);
            requeued = 1'b1;
        end
        if (!ring_pop(nxt))
            nxt = '0;
        if (nxt == old_id)
        begin
            if (requeued)
                task_st[old_id] = rrq_pkg::ST_RUNNING;
            return 1'b0;
        end
        cur_task = nxt;
        task_st[nxt] = rrq_pkg::ST_RUNNING;
        return 1'b1;
    endfunction

    function automatic sched_outcome_t sched_predict(rrq_pkg::rrq_cmd_t cmd,
                                                     rrq_pkg::rrq_id_t id);
        sched_outcome_t res;
        res.status = 1'b0;
        res.switched = 1'b0;
        res.prev = cur_task;
        case (cmd)
            rrq_pkg::CMD_CREATE:
            begin
                if (task_st[id] == rrq_pkg::ST_READY || task_st[id] == rrq_pkg::ST_RUNNING)
                    res.status = 1'b1;
                else
                    task_st[id] = rrq_pkg::ST_INITIAL;
            end
            rrq_pkg::CMD_START:
            begin
                if (task_st[id] != rrq_pkg::ST_INITIAL)
                    res.status = 1'b1;
                else
                begin
                    task_st[id] = rrq_pkg::ST_READY;
                    ring_push_head(id);
                end
            end
            rrq_pkg::CMD_RESCHED:
                res.switched = pick_next_task();
            default:
            begin
                task_st[cur_task] = rrq_pkg::ST_DEAD;
                res.switched = pick_next_task();
            end
        endcase
        res.run = cur_task;
        return res;
    endfunction

    function automatic logic find_task(rrq_pkg::rrq_tstate_t st,
                                       output rrq_pkg::rrq_id_t id);
        rrq_pkg::rrq_id_t hits [$];
        id = '0;
        for (int i = 0; i < TASKS; i++)
            if (task_st[i] == st)
                hits.push_back(rrq_pkg::rrq_id_t'(i));
        if (hits.size() == 0)
            return 1'b0;
        id = hits[$urandom_range(hits.size() - 1)];
        return 1'b1;
    endfunction

    task automatic add_row(rrq_pkg::rrq_cmd_t cmd, rrq_pkg::rrq_id_t id, logic typed,
                           logic st, logic sw, rrq_pkg::rrq_id_t pv,
                           rrq_pkg::rrq_id_t rn);
        plan_row_t row;
        row.cmd = cmd;
        row.id = id;
        row.typed = typed;
        row.res.status = st;
        row.res.switched = sw;
        row.res.prev = pv;
        row.res.run = rn;
        plan_q.push_back(row);
    endtask

    task automatic send_cmd(rrq_pkg::rrq_cmd_t cmd, rrq_pkg::rrq_id_t id, logic typed,
                            sched_outcome_t typed_res);
        sched_outcome_t res;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 34)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        command = cmd;
        task_id = id;
        do
            @(posedge clk);
        while (!in_ready);
        res = sched_predict(cmd, id);
        outcome_q.push_back(typed ? typed_res : res);
        sent_count++;
    endtask

    initial
    begin
        rrq_pkg::rrq_cmd_t cmd;
        rrq_pkg::rrq_id_t  id;
        rrq_pkg::rrq_id_t  alt;
        int                pick;
        plan_row_t         row;

        for (int i = 0; i < TASKS; i++)
        begin
            task_st[i] = rrq_pkg::ST_DEAD;
            ring[i] = '0;
        end
        task_st[0] = rrq_pkg::ST_INITIAL;
        ring_head = 0;
        ring_count = 0;
        cur_task = '0;

        //      command               id      typed  st    sw    prev   run
        add_row(rrq_pkg::CMD_RESCHED, 4'd0,  1'b1, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd5,  1'b1, 1'b1, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd15, 1'b1, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd0,  1'b1, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd15, 1'b1, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd15, 1'b1, 1'b1, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd15, 1'b1, 1'b1, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd10, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd10, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_RESCHED, 4'd9,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_RESCHED, 4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_RESCHED, 4'd15, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd15, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_EXIT,    4'd7,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_RESCHED, 4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd10, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd5,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd5,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd6,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_START,   4'd6,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_EXIT,    4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_EXIT,    4'd15, 1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_EXIT,    4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_EXIT,    4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);
        add_row(rrq_pkg::CMD_CREATE,  4'd0,  1'b0, 1'b0, 1'b0, 4'd0,  4'd0);

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        foreach (plan_q[i])
        begin
            row = plan_q[i];
            send_cmd(row.cmd, row.id, row.typed, row.res);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gaps_on = !(n >= 150 && n < 250);
            if (n == 300)
            begin
                // hold off until the block has drained
                @(negedge clk);
                in_valid = 1'b0;
                while (outcome_q.size() != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(99);
            id = rrq_pkg::rrq_id_t'($urandom_range(TASKS - 1));
            if (pick < 15)
                cmd = rrq_pkg::rrq_cmd_t'($urandom_range(3));
            else if (pick < 40)
            begin
                cmd = rrq_pkg::CMD_CREATE;
                if ($urandom_range(3) != 0 && find_task(rrq_pkg::ST_DEAD, alt))
                    id = alt;
            end
            else if (pick < 65)
            begin
                cmd = rrq_pkg::CMD_START;
                if ($urandom_range(4) != 0 && find_task(rrq_pkg::ST_INITIAL, alt))
                    id = alt;
            end
            else if (pick < 88)
                cmd = rrq_pkg::CMD_RESCHED;
            else
                cmd = rrq_pkg::CMD_EXIT;
            send_cmd(cmd, id, 1'b0, '0);
        end

        @(negedge clk);
        in_valid = 1'b0;
        gaps_on = 1'b1;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d commands (%0d from the directed table), %0d results",
                 sent_count, plan_q.size(), results_seen);
        $display("%0d task switches and %0d rejected commands observed, %0d mismatches",
                 switches_seen, rejects_seen, fail_count);
        if (fail_count == 0 && outcome_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(negedge clk)
    begin
        if (!gaps_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 34);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got.status = status;
            got.switched = switched;
            got.prev = previous_task;
            got.run = running_task;
            if (outcome_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result transfer: %s %0b %s %0b prev %0d run %0d",
                             "status", got.status, "switched", got.switched,
                             got.prev, got.run);
            end
            else
            begin
                want = outcome_q.pop_front();
                results_seen++;
                if (got.switched === 1'b1)
                    switches_seen++;
                if (got.status === 1'b1)
                    rejects_seen++;
                if (got.status !== want.status || got.switched !== want.switched ||
                    got.prev !== want.prev || got.run !== want.run)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                    begin
                        $display("result %0d mismatch: want st %0b sw %0b prev %0d run %0d",
                                 results_seen, want.status, want.switched, want.prev,
                                 want.run);
                        $display("    got st %0b sw %0b prev %0d run %0d",
                                 got.status, got.switched, got.prev, got.run);
                    end
                end
            end
        end
    end

    initial
    begin
        #3000000;
        $display("timeout with %0d results outstanding", outcome_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
